/* hw/rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check in the clk domain.
`define OFDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form: when ante holds, cons must hold.
`define OFDU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ofdu_pkg.sv */
package ofdu_pkg;

	localparam int TX_FIFO_DEPTH = 64;
	localparam int RX_FIFO_DEPTH = 64;
	localparam int TX_PTR_W = $clog2(TX_FIFO_DEPTH);
	localparam int RX_PTR_W = $clog2(RX_FIFO_DEPTH);

	typedef logic [TX_PTR_W-1:0] tx_ptr_t;
	typedef logic [RX_PTR_W-1:0] rx_ptr_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_TICK = 2'd0;
	localparam op_t OP_PUSH = 2'd1;
	localparam op_t OP_POP  = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_SAMPLING_FACTOR = 2'd0;
	localparam cfg_idx_t CFG_RX_PHASE_OFFSET = 2'd1;
	localparam cfg_idx_t CFG_TX_GUARD_BITS   = 2'd2;
	localparam cfg_idx_t CFG_RX_GUARD_BITS   = 2'd3;

	localparam logic [7:0] RST_SAMPLING_FACTOR = 8'd16;
	localparam logic [7:0] RST_RX_PHASE_OFFSET = 8'd8;
	localparam logic [3:0] RST_TX_GUARD_BITS   = 4'd3;
	localparam logic [3:0] RST_RX_GUARD_BITS   = 4'd2;

	// bit-state value of the last data/stop slot
	localparam logic [3:0] BIT_LAST = 4'd9;

endpackage

/* hw/rtl/ofdu_if.sv */
interface ofdu_in_if;
	import ofdu_pkg::*;
	logic       valid;
	logic       ready;
	op_t        op;
	logic       rx_line;
	logic [7:0] data_in;
	modport source (output valid, op, rx_line, data_in, input ready);
	modport sink   (input valid, op, rx_line, data_in, output ready);
endinterface

interface ofdu_out_if;
	logic       valid;
	logic       ready;
	logic       tx_line;
	logic [7:0] data_out;
	logic       ok;
	modport source (output valid, tx_line, data_out, ok, input ready);
	modport sink   (input valid, tx_line, data_out, ok, output ready);
endinterface

/* hw/rtl/ofdu_ram.sv */
module ofdu_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/oversampled_full_duplex_uart.sv */
// Two register stages, s2 and the output register, lie between an accepted word and its result.
// One word per cycle while the output is not stalled; the FIFO RAM read port sets the two-stage depth.
// Reset (arst_n low, async): engines idle, FIFOs empty, tx line high, registers at defaults.
// FIFO RAM contents are not cleared; only written entries are ever read.
module oversampled_full_duplex_uart (
	input  logic                      clk,
	input  logic                      arst_n,
	ofdu_in_if.sink                   in_ch,
	ofdu_out_if.source                out_ch,
	input  logic                      wr_en,
	input  ofdu_pkg::cfg_idx_t        wr_index,
	input  logic [7:0]                wr_data
);
	import ofdu_pkg::*;

	typedef struct packed {
		logic tx_line;
		logic ok;
		logic pop;
	} s2_t;

	// configuration registers
	logic [7:0] sampling_factor_q, rx_phase_offset_q;
	logic [3:0] tx_guard_bits_q, rx_guard_bits_q;

	// oversampling counter and engine state
	logic [7:0]  sample_count_q, sample_count_n;
	logic [7:0]  rx_phase_q, rx_phase_n;
	logic [3:0]  tx_bit_q, tx_bit_n;
	logic [7:0]  tx_shift_q, tx_shift_n, tx_shift_cur;
	logic [3:0]  tx_guard_q, tx_guard_n;
	logic        tx_level_q, tx_level_n;
	logic        tx_pend_q;
	tx_ptr_t     tx_rp_q, tx_rp_n, tx_wp_q, tx_wp_n, tx_wp_inc, tx_rp_inc;
	logic [3:0]  rx_bit_q, rx_bit_n;
	logic [7:0]  rx_shift_q, rx_shift_n, rx_shift_new;
	logic [11:0] rx_guard_q, rx_guard_n;
	rx_ptr_t     rx_rp_q, rx_rp_n, rx_wp_q, rx_wp_n, rx_wp_inc, rx_rp_inc;
	logic [7:0]  phase_sum;

	// RAM ports
	logic       tx_we, tx_re, rx_we, rx_re;
	logic [7:0] tx_rdata, rx_rdata;

	// pipeline
	logic       acc, ok_n, pop_n;
	logic       s2_v_q, out_v_q, s2_adv;
	s2_t        info_s2;
	logic       out_tx_q, out_ok_q;
	logic [7:0] out_data_q;

	assign acc    = in_ch.valid && in_ch.ready;
	assign s2_adv = !out_v_q || out_ch.ready;
	// input side only waits when both result slots are taken
	assign in_ch.ready = !s2_v_q || s2_adv;

	assign out_ch.valid    = out_v_q;
	assign out_ch.tx_line  = out_tx_q;
	assign out_ch.data_out = out_data_q;
	assign out_ch.ok       = out_ok_q;

	// ring pointer increments
	assign tx_wp_inc = (tx_wp_q == tx_ptr_t'(TX_FIFO_DEPTH - 1)) ? '0 : tx_wp_q + 1'b1;
	assign tx_rp_inc = (tx_rp_q == tx_ptr_t'(TX_FIFO_DEPTH - 1)) ? '0 : tx_rp_q + 1'b1;
	assign rx_wp_inc = (rx_wp_q == rx_ptr_t'(RX_FIFO_DEPTH - 1)) ? '0 : rx_wp_q + 1'b1;
	assign rx_rp_inc = (rx_rp_q == rx_ptr_t'(RX_FIFO_DEPTH - 1)) ? '0 : rx_rp_q + 1'b1;

	// A byte fetched from the tx FIFO lands in tx_rdata in the cycle after the
	// read; forward it so a factor of one can shift it out right away.
	assign tx_shift_cur = tx_pend_q ? tx_rdata : tx_shift_q;
	assign phase_sum    = sample_count_q + rx_phase_offset_q;
	assign rx_shift_new = {in_ch.rx_line, rx_shift_q[7:1]};

	always_comb begin
		sample_count_n = sample_count_q;
		rx_phase_n     = rx_phase_q;
		tx_bit_n       = tx_bit_q;
		tx_shift_n     = tx_shift_cur;
		tx_guard_n     = tx_guard_q;
		tx_level_n     = tx_level_q;
		tx_rp_n        = tx_rp_q;
		tx_wp_n        = tx_wp_q;
		rx_bit_n       = rx_bit_q;
		rx_shift_n     = rx_shift_q;
		rx_guard_n     = rx_guard_q;
		rx_rp_n        = rx_rp_q;
		rx_wp_n        = rx_wp_q;
		tx_we          = 1'b0;
		tx_re          = 1'b0;
		rx_we          = 1'b0;
		rx_re          = 1'b0;
		ok_n           = 1'b0;
		pop_n          = 1'b0;

		if (acc) begin
			case (in_ch.op)
				OP_TICK: begin
					ok_n = 1'b1;
					// transmitter: one step per bit period
					if (sample_count_q == '0) begin
						if (tx_bit_q == '0) begin
							if (tx_guard_q != '0) begin
								tx_guard_n = tx_guard_q - 1'b1;
							end else if (tx_rp_q != tx_wp_q) begin
								tx_re      = 1'b1;
								tx_rp_n    = tx_rp_inc;
								tx_level_n = 1'b0;
								tx_bit_n   = 4'd1;
							end
						end else if (tx_bit_q >= BIT_LAST) begin
							tx_level_n = 1'b1;
							tx_bit_n   = '0;
							tx_guard_n = tx_guard_bits_q;
						end else begin
							tx_level_n = tx_shift_cur[0];
							tx_shift_n = {1'b0, tx_shift_cur[7:1]};
							tx_bit_n   = tx_bit_q + 1'b1;
						end
					end
					// receiver: hunt for start, then sample at the fixed phase
					if (rx_bit_q == '0) begin
						if (rx_guard_q != '0) begin
							rx_guard_n = rx_guard_q - 1'b1;
						end else if (!in_ch.rx_line) begin
							rx_phase_n = (phase_sum >= sampling_factor_q) ?
								phase_sum - sampling_factor_q : phase_sum;
							rx_bit_n   = 4'd1;
						end
					end else if (sample_count_q == rx_phase_q) begin
						rx_shift_n = rx_shift_new;
						if (rx_bit_q >= BIT_LAST) begin
							// full FIFO drops the byte
							if (rx_wp_inc != rx_rp_q) begin
								rx_we   = 1'b1;
								rx_wp_n = rx_wp_inc;
							end
							rx_bit_n   = '0;
							rx_guard_n = 12'(rx_guard_bits_q) * 12'(sampling_factor_q);
						end else begin
							rx_bit_n = rx_bit_q + 1'b1;
						end
					end
					sample_count_n = sample_count_q + 1'b1;
					if (sample_count_n == sampling_factor_q) begin
						sample_count_n = '0;
					end
				end
				OP_PUSH: begin
					if (tx_wp_inc != tx_rp_q) begin
						tx_we   = 1'b1;
						tx_wp_n = tx_wp_inc;
						ok_n    = 1'b1;
					end
				end
				OP_POP: begin
					if (rx_rp_q != rx_wp_q) begin
						rx_re   = 1'b1;
						rx_rp_n = rx_rp_inc;
						ok_n    = 1'b1;
						pop_n   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	ofdu_ram #(.DEPTH(TX_FIFO_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_wp_q),
		.wdata (in_ch.data_in),
		.re    (tx_re),
		.raddr (tx_rp_q),
		.rdata (tx_rdata)
	);

	ofdu_ram #(.DEPTH(RX_FIFO_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wp_q),
		.wdata (rx_shift_new),
		.re    (rx_re),
		.raddr (rx_rp_q),
		.rdata (rx_rdata)
	);

	// configuration; writes take effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampling_factor_q <= RST_SAMPLING_FACTOR;
			rx_phase_offset_q <= RST_RX_PHASE_OFFSET;
			tx_guard_bits_q   <= RST_TX_GUARD_BITS;
			rx_guard_bits_q   <= RST_RX_GUARD_BITS;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SAMPLING_FACTOR: sampling_factor_q <= wr_data;
				CFG_RX_PHASE_OFFSET: rx_phase_offset_q <= wr_data;
				CFG_TX_GUARD_BITS:   tx_guard_bits_q   <= wr_data[3:0];
				CFG_RX_GUARD_BITS:   rx_guard_bits_q   <= wr_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			rx_phase_q     <= '0;
			tx_bit_q       <= '0;
			tx_shift_q     <= '0;
			tx_guard_q     <= '0;
			tx_level_q     <= 1'b1;
			tx_pend_q      <= 1'b0;
			tx_rp_q        <= '0;
			tx_wp_q        <= '0;
			rx_bit_q       <= '0;
			rx_shift_q     <= '0;
			rx_guard_q     <= '0;
			rx_rp_q        <= '0;
			rx_wp_q        <= '0;
		end else begin
			sample_count_q <= sample_count_n;
			rx_phase_q     <= rx_phase_n;
			tx_bit_q       <= tx_bit_n;
			tx_shift_q     <= tx_shift_n;
			tx_guard_q     <= tx_guard_n;
			tx_level_q     <= tx_level_n;
			tx_pend_q      <= tx_re;
			tx_rp_q        <= tx_rp_n;
			tx_wp_q        <= tx_wp_n;
			rx_bit_q       <= rx_bit_n;
			rx_shift_q     <= rx_shift_n;
			rx_guard_q     <= rx_guard_n;
			rx_rp_q        <= rx_rp_n;
			rx_wp_q        <= rx_wp_n;
		end
	end

	// result pipeline: s2 waits for RAM read data, output register holds the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				s2_v_q <= acc;
			end
			if (s2_adv) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s2 <= '{tx_line: tx_level_n, ok: ok_n, pop: pop_n};
		end
		if (s2_adv && s2_v_q) begin
			out_tx_q   <= info_s2.tx_line;
			out_ok_q   <= info_s2.ok;
			out_data_q <= info_s2.pop ? rx_rdata : 8'd0;
		end
	end
endmodule

/* hw/rtl/ofdu_checker.sv */
`include "assert_macros.svh"

module ofdu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_tx_line,
	input logic [7:0] out_data_out,
	input logic       out_ok
);
	`OFDU_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result word dropped")
	`OFDU_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({out_tx_line, out_data_out, out_ok}), "stalled result changed")
	`OFDU_ASSERT_IMP(a_data_needs_ok, out_valid && out_data_out != 8'd0, out_ok, "data without ok")
	`OFDU_ASSERT(a_two_cycle, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a word two cycles back")
endmodule

bind oversampled_full_duplex_uart ofdu_checker u_ofdu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_tx_line  (out_ch.tx_line),
	.out_data_out (out_ch.data_out),
	.out_ok       (out_ch.ok)
);

/* test/oversampled_full_duplex_uart_tb.sv */
module oversampled_full_duplex_uart_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ofdu_pkg::*;

	// op code the block must ignore
	localparam op_t OP_UNUSED = 2'd3;
	// cycles without any word moving before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic       tx_line;
		logic [7:0] data_out;
		logic       ok;
	} uart_word_t;

	// one random phase: register settings and word count
	typedef struct packed {
		int factor;
		int offset;
		int txg;
		int rxg;
		int words;
	} sweep_step_t;

	// Extremes: factor 1, 255 and 0, offset at and above the factor, guards 0 and 15.
	// The step after factor 255 lowers the factor under the running counter.
	localparam sweep_step_t SWEEP[9] = '{
		'{4,   2,   0,  0,  100},
		'{3,   1,   15, 15, 100},
		'{1,   0,   1,  1,  100},
		'{8,   4,   7,  3,  100},
		'{5,   254, 2,  1,  80},
		'{255, 255, 4,  15, 100},
		'{6,   0,   0,  15, 100},
		'{0,   3,   15, 0,  60},
		'{16,  8,   3,  2,  60}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	cfg_idx_t   wr_index;
	logic [7:0] wr_data;

	ofdu_in_if  in_ch();
	ofdu_out_if out_ch();

	oversampled_full_duplex_uart dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// --------------------------------------------------------------------
	// Behavioral copy of the UART: registers, engines and the two FIFOs.
	// FIFOs are plain queues capped at DEPTH-1 entries (one slot kept free).
	// --------------------------------------------------------------------
	logic [7:0]  cfg_factor, cfg_offset;
	logic [3:0]  cfg_tx_guard, cfg_rx_guard;

	logic [7:0]  tick_count;   // oversampling counter
	logic [7:0]  rx_phase;     // counter value at which the receiver samples
	logic [3:0]  tx_slot;      // 0 idle/stop, 1 start bit, 2..9 data bits
	logic [7:0]  tx_bits;
	logic [3:0]  tx_rest;      // idle bit periods left after a stop bit
	logic        line_out;
	logic [3:0]  rx_slot;
	logic [7:0]  rx_bits;
	logic [11:0] rx_rest;      // ticks left before looking for a start bit
	logic [7:0]  tx_backlog[$];
	logic [7:0]  rx_backlog[$];

	uart_word_t  awaited[$];   // predicted output words, oldest first
	bit          rx_wave[$];   // planned rx line levels for upcoming ticks

	int mismatches = 0;
	int quiet = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;

	function automatic void uart_clear();
		cfg_factor   = RST_SAMPLING_FACTOR;
		cfg_offset   = RST_RX_PHASE_OFFSET;
		cfg_tx_guard = RST_TX_GUARD_BITS;
		cfg_rx_guard = RST_RX_GUARD_BITS;
		tick_count   = '0;
		rx_phase     = '0;
		tx_slot      = '0;
		tx_bits      = '0;
		tx_rest      = '0;
		line_out     = 1'b1;
		rx_slot      = '0;
		rx_bits      = '0;
		rx_rest      = '0;
		tx_backlog.delete();
		rx_backlog.delete();
	endfunction

	// Advance the UART by one word and return what the block should emit.
	function automatic uart_word_t uart_response(op_t op, logic line, logic [7:0] data);
		uart_word_t w;
		logic [7:0] ph;
		w = '0;
		case (op)
			OP_TICK: begin
				// transmitter moves once per bit period, on counter zero
				if (tick_count == 8'd0) begin
					if (tx_slot == 4'd0) begin
						if (tx_rest == 4'd0) begin
							if (tx_backlog.size() != 0) begin
								tx_bits  = tx_backlog.pop_front();
								line_out = 1'b0;
								tx_slot  = 4'd1;
							end
						end else begin
							tx_rest = tx_rest - 4'd1;
						end
					end else if (tx_slot >= BIT_LAST) begin
						line_out = 1'b1;
						tx_slot  = 4'd0;
						tx_rest  = cfg_tx_guard;
					end else begin
						line_out = tx_bits[0];
						tx_bits  = tx_bits >> 1;
						tx_slot  = tx_slot + 4'd1;
					end
				end
				// receiver: start search after guard, then 9 samples at the fixed phase
				if (rx_slot == 4'd0) begin
					if (rx_rest == 12'd0) begin
						if (!line) begin
							ph = tick_count + cfg_offset;
							if (ph >= cfg_factor)
								ph = ph - cfg_factor;
							rx_phase = ph;
							rx_slot  = 4'd1;
						end
					end else begin
						rx_rest = rx_rest - 12'd1;
					end
				end else if (tick_count == rx_phase) begin
					rx_bits = {line, rx_bits[7:1]};
					if (rx_slot >= BIT_LAST) begin
						// full FIFO drops the byte without a trace
						if (rx_backlog.size() < RX_FIFO_DEPTH - 1)
							rx_backlog.push_back(rx_bits);
						rx_slot = 4'd0;
						rx_rest = 12'(cfg_rx_guard) * 12'(cfg_factor);
					end else begin
						rx_slot = rx_slot + 4'd1;
					end
				end
				tick_count = tick_count + 8'd1;
				if (tick_count == cfg_factor)
					tick_count = 8'd0;
				w.ok = 1'b1;
			end
			OP_PUSH: begin
				if (tx_backlog.size() < TX_FIFO_DEPTH - 1) begin
					tx_backlog.push_back(data);
					w.ok = 1'b1;
				end
			end
			OP_POP: begin
				if (rx_backlog.size() != 0) begin
					w.data_out = rx_backlog.pop_front();
					w.ok       = 1'b1;
				end
			end
			default: ;
		endcase
		w.tx_line = line_out;
		return w;
	endfunction

	// --------------------------------------------------------------------
	// Output side: random back-pressure, in-order compare, hang watchdog.
	// --------------------------------------------------------------------
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		uart_word_t seen, want;
		if (out_ch.valid && out_ch.ready) begin
			seen = '{out_ch.tx_line, out_ch.data_out, out_ch.ok};
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected word tx_line=%0b data_out=%02h ok=%0b",
						$time, seen.tx_line, seen.data_out, seen.ok);
			end else begin
				want = awaited.pop_front();
				if (seen.tx_line !== want.tx_line || seen.data_out !== want.data_out ||
						seen.ok !== want.ok) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display(
							"%0t: exp tx=%0b data=%02h ok=%0b, got tx=%0b data=%02h ok=%0b",
							$time, want.tx_line, want.data_out, want.ok,
							seen.tx_line, seen.data_out, seen.ok);
				end
			end
		end
		// any moved word on either side proves the block is alive
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Input side helpers.
	// --------------------------------------------------------------------

	// Send one word, with random sender gaps; prediction is taken on acceptance.
	task automatic send_word(op_t op, logic line, logic [7:0] data);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.op      <= op;
		in_ch.rx_line <= line;
		in_ch.data_in <= data;
		do @(posedge clk); while (!in_ch.ready);
		awaited.push_back(uart_response(op, line, data));
	endtask

	// Stop sending and let every predicted word come back, plus pipeline slack.
	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [7:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_SAMPLING_FACTOR: cfg_factor   = val;
			CFG_RX_PHASE_OFFSET: cfg_offset   = val;
			CFG_TX_GUARD_BITS:   cfg_tx_guard = val[3:0];
			CFG_RX_GUARD_BITS:   cfg_rx_guard = val[3:0];
			default: ;
		endcase
	endtask

	// Only called with the block drained; wr_en drops after the last write.
	task automatic write_regs(logic [7:0] factor, logic [7:0] offset,
			logic [3:0] txg, logic [3:0] rxg);
		put_reg(CFG_SAMPLING_FACTOR, factor);
		put_reg(CFG_RX_PHASE_OFFSET, offset);
		put_reg(CFG_TX_GUARD_BITS, {4'd0, txg});
		put_reg(CFG_RX_GUARD_BITS, {4'd0, rxg});
		wr_en <= 1'b0;
		rx_wave.delete();
	endtask

	// Queue an 8N1 frame on the rx line: start, 8 data bits LSB first, stop.
	function automatic void plan_frame(logic [7:0] b);
		int bit_len;
		bit_len = (cfg_factor == 8'd0) ? 3 : int'(cfg_factor);
		for (int k = 0; k < 10; k++)
			repeat (bit_len)
				rx_wave.push_back((k == 0) ? 1'b0 : (k == 9) ? 1'b1 : b[k-1]);
	endfunction

	task automatic play_wave();
		while (rx_wave.size() != 0)
			send_word(OP_TICK, rx_wave.pop_front(), 8'($urandom_range(255)));
	endtask

	// Next rx level for a random tick: mostly clean frames, some cut short, some noise.
	function automatic bit next_rx_level();
		int r, bit_len, keep;
		if (rx_wave.size() == 0) begin
			bit_len = (cfg_factor == 8'd0) ? 3 : int'(cfg_factor);
			r = $urandom_range(99);
			if (r < 70) begin
				repeat ($urandom_range(2 * bit_len))
					rx_wave.push_back(1'b1);
				plan_frame(8'($urandom_range(255)));
				// broken frame: line returns high partway through
				if (r < 10) begin
					keep = $urandom_range(1, rx_wave.size());
					while (rx_wave.size() > keep)
						void'(rx_wave.pop_back());
				end
			end else if (r < 85) begin
				rx_wave.push_back(1'($urandom_range(1)));
			end else begin
				rx_wave.push_back(1'b1);
			end
		end
		return rx_wave.pop_front();
	endfunction

	task automatic run_traffic(int words, int w_push, int w_pop, int w_unused);
		int r;
		repeat (words) begin
			r = $urandom_range(99);
			if (r < w_push)
				send_word(OP_PUSH, 1'($urandom_range(1)), 8'($urandom_range(255)));
			else if (r < w_push + w_pop)
				send_word(OP_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
			else if (r < w_push + w_pop + w_unused)
				send_word(OP_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(255)));
			else
				send_word(OP_TICK, next_rx_level(), 8'($urandom_range(255)));
		end
	endtask

	// --------------------------------------------------------------------
	// Tests.
	// --------------------------------------------------------------------

	// Empty pop, ignored op, byte extremes, then one clean frame at factor 1.
	task automatic test_directed();
		send_word(OP_POP, 1'b0, 8'h00);
		send_word(OP_UNUSED, 1'b0, 8'hFF);
		send_word(OP_PUSH, 1'b1, 8'h00);
		send_word(OP_PUSH, 1'b0, 8'hFF);
		send_word(OP_PUSH, 1'b1, 8'h80);
		send_word(OP_PUSH, 1'b0, 8'h01);
		hold_until_drained();
		write_regs(8'd1, 8'd0, 4'd0, 4'd0);
		plan_frame(8'hA5);
		play_wave();
		send_word(OP_POP, 1'b1, 8'h5A);
		send_word(OP_POP, 1'b0, 8'hC3);
	endtask

	// More pushes than the transmit FIFO holds; the overflow is refused.
	task automatic test_tx_fifo_full();
		repeat (TX_FIFO_DEPTH)
			send_word(OP_PUSH, 1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	// Back-to-back frames with no pops until received bytes are dropped, then empty it.
	task automatic test_rx_fifo_overflow();
		hold_until_drained();
		write_regs(8'd1, 8'd0, 4'd3, 4'd0);
		repeat (RX_FIFO_DEPTH + 2) begin
			plan_frame(8'($urandom_range(255)));
			play_wave();
		end
		repeat (RX_FIFO_DEPTH)
			send_word(OP_POP, 1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	// Random traffic over a range of settings; idle pattern changes every third step.
	task automatic test_config_sweep();
		for (int s = 0; s < 9; s++) begin
			if (s == 3) begin
				snd_idle_pct = 80;
				rcv_idle_pct = 11;
			end else if (s == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			hold_until_drained();
			write_regs(8'(SWEEP[s].factor), 8'(SWEEP[s].offset),
				4'(SWEEP[s].txg), 4'(SWEEP[s].rxg));
			run_traffic(SWEEP[s].words / 2, 8, 8, 2);
			// sender waits for every outstanding word mid-step
			hold_until_drained();
			run_traffic(SWEEP[s].words - SWEEP[s].words / 2, 8, 8, 2);
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		wr_en         <= 1'b0;
		wr_index      <= CFG_SAMPLING_FACTOR;
		wr_data       <= 8'd0;
		in_ch.valid   <= 1'b0;
		in_ch.op      <= OP_TICK;
		in_ch.rx_line <= 1'b1;
		in_ch.data_in <= 8'd0;
		uart_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender rarely idles, receiver mostly stalls
		snd_idle_pct = 11;
		rcv_idle_pct = 80;

		test_directed();
		test_tx_fifo_full();
		test_rx_fifo_overflow();
		test_config_sweep();

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ofdu_pkg.sv
hw/rtl/ofdu_if.sv
hw/rtl/ofdu_ram.sv
hw/rtl/oversampled_full_duplex_uart.sv
hw/rtl/ofdu_checker.sv
test/oversampled_full_duplex_uart_tb.sv
